// ===== sv/psv_pkg.sv =====
// Shared types, constants and helper functions for the polygon segment visibility block.
// Depends on nothing; every other file except psv_ram imports it.
package psv_pkg;

  // Sizes
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 32;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int NUM_W        = VIDX_W + 1;
  localparam int CNT_W        = 9;
  localparam int EPS_W        = 40;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 40;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS          = 2'd1;

  // Orientation codes
  localparam logic [1:0] ORI_COLL = 2'd0;
  localparam logic [1:0] ORI_CW   = 2'd1;
  localparam logic [1:0] ORI_CCW  = 2'd2;

  typedef struct packed {
    logic              op;
    logic [7:0]        vertex_index;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] query_start_x;
    logic signed [31:0] query_start_y;
    logic signed [31:0] query_end_x;
    logic signed [31:0] query_end_y;
  } in_item_t;

  typedef struct packed {
    logic visible;
    logic point_query;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  // Query entry in the front-to-back queue
  typedef struct packed {
    pt_t  q;
    pt_t  r;
    logic pt;
  } query_t;

  // Vertex store write
  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] addr;
    pt_t               v;
  } vtx_wr_t;

  // Low COORD_BITS of a field, sign carried
  function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [31:0] raw);
    coord_of = $signed(raw[COORD_BITS-1:0]);
  endfunction

  // p inside the closed bounding box of a and b
  function automatic logic in_box(input pt_t p, input pt_t a, input pt_t b);
    logic signed [COORD_BITS-1:0] xl, xh, yl, yh;
    xl = (a.x < b.x) ? a.x : b.x;
    xh = (a.x < b.x) ? b.x : a.x;
    yl = (a.y < b.y) ? a.y : b.y;
    yh = (a.y < b.y) ? b.y : a.y;
    in_box = (p.x >= xl) && (p.x <= xh) && (p.y >= yl) && (p.y <= yh);
  endfunction

endpackage

// ===== sv/psv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/psv_front.sv =====
// Front end: accepts items, writes loads into the vertex store, queues queries.
// Depends on psv_pkg.
module psv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psv_pkg::in_item_t in_data,
  output psv_pkg::vtx_wr_t  vtx_wr,
  input  logic              back_idle,
  output logic              q_valid,
  input  logic              q_pop,
  output psv_pkg::query_t   q_data
);
  import psv_pkg::*;

  query_t     fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       fifo_empty, fifo_full, push;
  query_t     entry;

  assign fifo_empty = (fill_r == 2'd0);
  assign fifo_full  = (fill_r == 2'd2);

  // Loads wait until every earlier query has finished its walk
  always_comb begin
    case (in_data.op)
      OP_LOAD: in_ready = fifo_empty && back_idle;
      default: in_ready = !fifo_full;
    endcase
  end

  // Classify the query
  always_comb begin
    entry.q.x = coord_of(in_data.query_start_x);
    entry.q.y = coord_of(in_data.query_start_y);
    entry.r.x = coord_of(in_data.query_end_x);
    entry.r.y = coord_of(in_data.query_end_y);
    entry.pt  = (entry.q == entry.r);
  end

  // Vertex store write
  always_comb begin
    vtx_wr.we   = in_valid && in_ready && (in_data.op == OP_LOAD) &&
                  (int'(in_data.vertex_index) < MAX_VERTICES);
    vtx_wr.addr = VIDX_W'(in_data.vertex_index);
    vtx_wr.v.x  = coord_of(in_data.vertex_x);
    vtx_wr.v.y  = coord_of(in_data.vertex_y);
  end

  assign push    = in_valid && in_ready && (in_data.op == OP_QUERY);
  assign q_valid = !fifo_empty;
  assign q_data  = fifo_r[rd_ptr_r];

  // Two-entry query queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        fifo_r[wr_ptr_r] <= entry;
        wr_ptr_r         <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== sv/psv_orient.sv =====
// Three-stage cross product unit: differences, two products, subtract.
// Depends on psv_pkg.
module psv_orient (
  input  logic                                  clk,
  input  psv_pkg::pt_t                          a,
  input  psv_pkg::pt_t                          b,
  input  psv_pkg::pt_t                          c,
  output logic signed [psv_pkg::CROSS_W-1:0]    xprod
);
  import psv_pkg::*;

  logic signed [DIFF_W-1:0]  d1_r, d2_r, d3_r, d4_r;
  logic signed [PROD_W-1:0]  p1_r, p2_r;
  logic signed [CROSS_W-1:0] xprod_r;

  // (b-a) x (c-a)
  always_ff @(posedge clk) begin
    d1_r    <= DIFF_W'(b.x) - DIFF_W'(a.x);
    d2_r    <= DIFF_W'(c.y) - DIFF_W'(a.y);
    d3_r    <= DIFF_W'(b.y) - DIFF_W'(a.y);
    d4_r    <= DIFF_W'(c.x) - DIFF_W'(a.x);
    p1_r    <= d1_r * d2_r;
    p2_r    <= d3_r * d4_r;
    xprod_r <= CROSS_W'(p1_r) - CROSS_W'(p2_r);
  end

  assign xprod = xprod_r;

endmodule

// ===== sv/psv_back.sv =====
// Back end: walks the polygon edges for one query and produces its result.
// Depends on psv_pkg and psv_orient.
module psv_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  psv_pkg::query_t              q_data,
  output logic                         back_idle,
  input  logic [psv_pkg::NUM_W-1:0]    n_used,
  input  logic [psv_pkg::EPS_W-1:0]    eps,
  output logic [psv_pkg::VIDX_W-1:0]   raddr,
  input  psv_pkg::pt_t                 rd_pt,
  output logic                         out_valid,
  input  logic                         out_ready,
  output psv_pkg::out_item_t           out_data
);
  import psv_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FIRST, S_LOAD, S_EDGE, S_DONE} state_t;

  state_t                   state_r;
  query_t                   qry_r;
  pt_t                      first_r, e1_r, e2_r;
  logic [VIDX_W-1:0]        edge_r;
  logic [2:0]               ph_r;
  logic [1:0]               ori_r [4];
  logic                     pneg_r, ppos_r, inside_r, res_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;
  pt_t                      oa, ob, oc;
  logic signed [CROSS_W-1:0] xprod;
  logic [CROSS_W-1:0]       mag;
  logic                     neg, coll;
  logic [1:0]               ori_now;
  logic                     hits, same, blocked, straddle, left, inside_nxt;
  logic                     last_edge, wrap_edge;

  // Operand select for the shared cross product unit
  always_comb begin
    oa = e1_r; ob = qry_r.q; oc = e2_r;
    if (!qry_r.pt) begin
      case (ph_r[1:0])
        2'd0:    begin oa = qry_r.q; ob = qry_r.r; oc = e1_r;    end
        2'd1:    begin oa = qry_r.q; ob = qry_r.r; oc = e2_r;    end
        2'd2:    begin oa = e1_r;    ob = e2_r;    oc = qry_r.q; end
        default: begin oa = e1_r;    ob = e2_r;    oc = qry_r.r; end
      endcase
    end
  end

  psv_orient u_orient (.clk(clk), .a(oa), .b(ob), .c(oc), .xprod(xprod));

  // Orientation class of the product that just came out
  always_comb begin
    neg  = xprod[CROSS_W-1];
    mag  = neg ? CROSS_W'(-xprod) : CROSS_W'(xprod);
    coll = (mag[CROSS_W-1:EPS_W] == '0) && (mag[EPS_W-1:0] < eps);
    ori_now = coll ? ORI_COLL : (neg ? ORI_CW : ORI_CCW);
  end

  // Edge verdict
  always_comb begin
    hits = (ori_r[0] != ori_r[1]) && (ori_r[2] != ori_r[3]);
    same = (qry_r.q == e1_r) || (qry_r.q == e2_r) || (qry_r.r == e1_r) || (qry_r.r == e2_r);
    blocked = hits && !same && !in_box(e1_r, qry_r.q, qry_r.r) &&
              !in_box(e2_r, qry_r.q, qry_r.r);
    straddle   = (e1_r.y > qry_r.q.y) != (e2_r.y > qry_r.q.y);
    left       = (e2_r.y > e1_r.y) ? pneg_r : ppos_r;
    inside_nxt = inside_r ^ (straddle && left);
    last_edge  = (NUM_W'(edge_r) + NUM_W'(1)) == n_used;
    wrap_edge  = (NUM_W'(edge_r) + NUM_W'(2)) == n_used;
  end

  // Vertex store read address
  always_comb begin
    unique case (state_r)
      S_IDLE:  raddr = '0;
      S_FIRST: raddr = VIDX_W'(1);
      S_EDGE:  raddr = VIDX_W'(NUM_W'(edge_r) + NUM_W'(2));
      default: raddr = '0;
    endcase
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign back_idle = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Walk sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result taken and nothing new to hand over
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            qry_r    <= q_data;
            inside_r <= 1'b0;
            edge_r   <= '0;
            res_r    <= !q_data.pt;
            state_r  <= (n_used == '0) ? S_DONE : S_FIRST;
          end
        end
        S_FIRST: begin
          first_r <= rd_pt;
          e1_r    <= rd_pt;
          e2_r    <= rd_pt;
          ph_r    <= '0;
          state_r <= (n_used == NUM_W'(1)) ? S_EDGE : S_LOAD;
        end
        S_LOAD: begin
          e1_r    <= e2_r;
          e2_r    <= rd_pt;
          ph_r    <= '0;
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          ph_r <= ph_r + 3'd1;
          // each product arrives after the unit's difference, product and subtract registers
          if (ph_r >= 3'd3 && ph_r <= 3'd6) begin
            ori_r[2'(ph_r - 3'd3)] <= ori_now;
          end
          if (ph_r == 3'd3) begin
            pneg_r <= neg;
            ppos_r <= !neg && (xprod != '0);
          end
          if (ph_r == 3'd7) begin
            if (!qry_r.pt && blocked) begin
              res_r   <= 1'b0;
              state_r <= S_DONE;
            end else if (qry_r.pt && in_box(qry_r.q, e1_r, e2_r)) begin
              res_r   <= 1'b1;
              state_r <= S_DONE;
            end else if (last_edge) begin
              res_r   <= qry_r.pt ? inside_nxt : 1'b1;
              state_r <= S_DONE;
            end else begin
              inside_r <= inside_nxt;
              edge_r   <= edge_r + VIDX_W'(1);
              if (wrap_edge) begin
                e1_r <= e2_r;
                e2_r <= first_r;
              end else begin
                state_r <= S_LOAD;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.visible     <= res_r;
            out_data_r.point_query <= qry_r.pt;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/polygon_segment_visibility.sv =====
// Top level: configuration registers, vertex store, front end and edge walker.
// Depends on psv_pkg, psv_ram, psv_front, psv_back.
//
// Use: a load item (op 0) writes one vertex into the store; it gives no result.
// A query item (op 1) gives segment q-r and yields one result item: visible,
// and point_query when q equals r (then visible means the point is inside).
// Input and result channels are valid/ready; configuration is a plain write
// port (vertex_count at index 0, eps_threshold at index 1), written while idle.
// Queries wait in a two-entry queue; a load is taken only once all earlier
// queries are finished, so the store never changes under a walk.
// The edge walker handles one edge at a time, reading its next vertex and
// then running the four cross products through one pipelined unit; a
// query's walk ends early when an edge settles it, and the walker takes the
// next query from the queue only after it has finished the current one.
// Results sit in an output register; a stalled receiver holds the walker in
// its final state while the queue still takes queries until it is full.
// Reset (synchronous, active low) sets vertex_count to 3, eps to 0 and empties
// the queue; the vertex store is not cleared.
module polygon_segment_visibility (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  psv_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output psv_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [psv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import psv_pkg::*;

  logic [CNT_W-1:0]  vertex_count_r;
  logic [EPS_W-1:0]  eps_threshold_r;
  logic [NUM_W-1:0]  n_used;
  vtx_wr_t           vtx_wr;
  logic              back_idle, q_valid, q_pop;
  query_t            q_data;
  logic [VIDX_W-1:0] raddr;
  pt_t               rd_pt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r  <= CNT_W'(3);
      eps_threshold_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_EPS:          eps_threshold_r <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertex count capped at the store depth
  assign n_used = (int'(vertex_count_r) > MAX_VERTICES) ? NUM_W'(MAX_VERTICES)
                                                         : NUM_W'(vertex_count_r);

  psv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .vtx_wr(vtx_wr), .back_idle(back_idle),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  psv_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_x (
    .clk(clk), .we(vtx_wr.we), .waddr(vtx_wr.addr), .wdata(vtx_wr.v.x),
    .raddr(raddr), .rdata(rd_pt.x)
  );

  psv_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_y (
    .clk(clk), .we(vtx_wr.we), .waddr(vtx_wr.addr), .wdata(vtx_wr.v.y),
    .raddr(raddr), .rdata(rd_pt.y)
  );

  psv_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .back_idle(back_idle), .n_used(n_used), .eps(eps_threshold_r),
    .raddr(raddr), .rd_pt(rd_pt), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

// ===== sv/psv_checker.sv =====
// Port-level checks for the polygon segment visibility block, bound to the top.
// Depends on psv_pkg.
module psv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input psv_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input psv_pkg::out_item_t out_data
);
  import psv_pkg::*;

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_LOAD |=> !$rose(out_valid))
    else $error("result appeared after a load");

endmodule

bind polygon_segment_visibility psv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
